FILE: sv/bfra_pkg.sv
// Shared types and constants of the best-fit region allocator.
package bfra_pkg;

	localparam int unsigned ADDR_W = 20;
	localparam int unsigned SIZE_W = 21;
	localparam int unsigned GF_W   = 7;

	localparam logic [SIZE_W-1:0] INIT_CAP_RST = 21'd1024;
	localparam logic [GF_W-1:0]   GF_RST       = 7'd32;
	localparam logic [GF_W-1:0]   GF_UNIT      = 7'd16;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_FREE    = 2'd1;
	localparam logic [1:0] REQ_REALLOC = 2'd2;

	localparam logic CFG_INIT_CAP = 1'b0;
	localparam logic CFG_GROWTH   = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_NOENT   = 2'd2,
		ST_NOSPACE = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_INIT, OP_ACCEPT, OP_DISP, OP_FIND_RD, OP_FIND_CHK,
		OP_FP_RD, OP_FP_CHK, OP_FN_RD, OP_FN_CHK, OP_FW, OP_SH_RD, OP_SH_WR,
		OP_AF, OP_AS_RD, OP_AS_CHK, OP_BEST_WR, OP_SET_SMALL, OP_SET_NC,
		OP_IN_RD, OP_IN_WR, OP_GROW_STEP, OP_GCHK, OP_GW2, OP_LOAD_OUT
	} op_t;

	typedef struct packed {
		op_t     op;
		logic    set_res;
		status_t st;
		logic    res_addr;
	} cmd_t;

	typedef struct packed {
		logic       init_pend;
		logic [1:0] req_type;
		logic       size_zero;
		logic       match;
		logic       rd_free;
		logic       same;
		logic       i_last;
		logic       has_prev;
		logic       has_next;
		logic       k_zero;
		logic       sh_more;
		logic       best_valid;
		logic       best_ovf;
		logic       best_exact;
		logic       in_more;
		logic       small_gf;
		logic       small_fail;
		logic       grow_done;
		logic       grow_fail;
		logic       slots_fail;
		logic       gleft_pos;
		logic       out_free;
	} flags_t;

endpackage

FILE: sv/bfra_if.sv
// Request and response channel interfaces of the region allocator.
interface bfra_req_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    req_type;
	logic [bfra_pkg::ADDR_W-1:0]   address;
	logic [bfra_pkg::SIZE_W-1:0]   request_size;
	modport source(output valid, req_type, address, request_size, input ready);
	modport sink(input valid, req_type, address, request_size, output ready);
endinterface

interface bfra_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [bfra_pkg::ADDR_W-1:0]   result_address;
	logic                          resized;
	modport source(output valid, status, result_address, resized, input ready);
	modport sink(input valid, status, result_address, resized, output ready);
endinterface

FILE: sv/bfra_dp.sv
// Datapath: region table memory, scan registers, growth arithmetic, output register.
module bfra_dp #(
	parameter int MAX_REGIONS  = 64,
	parameter int MAX_CAPACITY = 1048576
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bfra_pkg::cmd_t              cmd,
	output bfra_pkg::flags_t            fl,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [bfra_pkg::SIZE_W-1:0] cfg_wdata,
	input  logic [1:0]                  in_req_type,
	input  logic [bfra_pkg::ADDR_W-1:0] in_address,
	input  logic [bfra_pkg::SIZE_W-1:0] in_request_size,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic [1:0]                  out_status,
	output logic [bfra_pkg::ADDR_W-1:0] out_address,
	output logic                        out_resized
);
	import bfra_pkg::*;

	localparam int CW = $clog2(MAX_CAPACITY + 1);
	localparam int LW = ((CW > SIZE_W) ? CW : SIZE_W) + 2;
	localparam int PW = LW + GF_W;
	localparam int IW = $clog2(MAX_REGIONS);
	localparam int NW = $clog2(MAX_REGIONS + 1);
	localparam int EW = 2 * CW + 1;
	localparam logic [LW-1:0] MAXC = LW'(MAX_CAPACITY);
	localparam logic [NW:0]   MAXR = (NW+1)'(MAX_REGIONS);

	function automatic logic [ADDR_W-1:0] to_addr(input logic [CW-1:0] s);
		logic [LW-1:0] t;
		t = LW'(s);
		return t[ADDR_W-1:0];
	endfunction

	logic [EW-1:0] mem [MAX_REGIONS];
	logic [EW-1:0] rd_q;
	logic          we;
	logic [IW-1:0] wa, ra;
	logic [EW-1:0] wd;

	logic [SIZE_W-1:0] init_q;
	logic [GF_W-1:0]   gf_q;
	logic              init_pend_q;
	logic [CW-1:0]     cap_q;
	logic [NW-1:0]     count_q;
	logic              out_valid_q;

	logic [1:0]        type_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIZE_W-1:0] size_q;
	logic [NW-1:0]     i_q, e_idx_q, lo_q, hi_q, j_q, k_q, b_idx_q, pos_q;
	logic [CW-1:0]     e_start_q, e_len_q, cur_start_q, cur_len_q;
	logic [CW-1:0]     b_start_q, b_len_q, last_start_q, last_len_q, n_start_q, n_len_q;
	logic              bv_q, last_free_q;
	logic [LW-1:0]     newcap_q;
	status_t           status_q;
	logic [ADDR_W-1:0] raddr_q;
	logic              resized_q;
	logic [1:0]        o_status_q;
	logic [ADDR_W-1:0] o_addr_q;
	logic              o_resized_q;

	logic [CW-1:0] rd_start, rd_len;
	logic          rd_free;
	logic [LW-1:0] size_l, cap_l, have_l, gsum, small_nc, left_g, init_l, init_c;
	logic [CW-1:0] size_c;
	logic [PW-1:0] prod, nx_raw, nx1, nx_sat;
	logic [LW-1:0] step_nc;
	logic [NW:0]   slots, gcount, jk, ep1, bp1, pp1, lp1;
	logic [NW-1:0] pidx, em1;
	logic [CW-1:0] pstart;
	logic          cand;

	assign rd_start = rd_q[2*CW:CW+1];
	assign rd_len   = rd_q[CW:1];
	assign rd_free  = rd_q[0];

	assign size_l   = LW'(size_q);
	assign size_c   = size_l[CW-1:0];
	assign cap_l    = LW'(cap_q);
	assign have_l   = last_free_q ? LW'(last_len_q) : '0;
	assign gsum     = have_l + newcap_q - cap_l;
	assign small_nc = cap_l + size_l - have_l;
	assign left_g   = gsum - size_l;
	assign init_l   = LW'(init_q);

	always_comb begin
		init_c = init_l;
		if (init_l == '0) init_c = LW'(1);
		else if (init_l > MAXC) init_c = MAXC;
	end

	assign prod   = PW'(newcap_q) * PW'(gf_q);
	assign nx_raw = prod >> 4;
	always_comb begin
		nx1 = nx_raw;
		if (nx_raw <= PW'(newcap_q)) nx1 = PW'(newcap_q) + PW'(1);
		nx_sat = (nx1 > PW'(MAXC)) ? PW'(MAXC) : nx1;
	end
	assign step_nc = nx_sat[LW-1:0];

	assign slots  = (NW+1)'(last_free_q ? 0 : 1) + (NW+1)'(left_g != '0);
	assign pidx   = last_free_q ? count_q - NW'(1) : count_q;
	assign pstart = last_free_q ? last_start_q : cap_q;
	assign lp1    = (NW+1)'(pidx) + (NW+1)'(1);
	assign gcount = lp1 + (NW+1)'(left_g != '0);
	assign jk     = (NW+1)'(j_q) + (NW+1)'(k_q);
	assign ep1    = (NW+1)'(e_idx_q) + (NW+1)'(1);
	assign em1    = e_idx_q - NW'(1);
	assign bp1    = (NW+1)'(b_idx_q) + (NW+1)'(1);
	assign pp1    = lp1;
	assign cand   = rd_free && (LW'(rd_len) >= size_l) && (!bv_q || rd_len < b_len_q);

	always_comb begin
		fl.init_pend  = init_pend_q;
		fl.req_type   = type_q;
		fl.size_zero  = (size_q == '0);
		fl.match      = (LW'(rd_start) == LW'(addr_q));
		fl.rd_free    = rd_free;
		fl.same       = (LW'(rd_len) == size_l);
		fl.i_last     = (i_q == count_q - NW'(1));
		fl.has_prev   = (e_idx_q != '0);
		fl.has_next   = (ep1 < (NW+1)'(count_q));
		fl.k_zero     = (hi_q == lo_q);
		fl.sh_more    = (jk < (NW+1)'(count_q));
		fl.best_valid = bv_q;
		fl.best_exact = (LW'(b_len_q) == size_l);
		fl.best_ovf   = !fl.best_exact && ((NW+1)'(count_q) >= MAXR);
		fl.in_more    = (j_q > pos_q);
		fl.small_gf   = (gf_q <= GF_UNIT);
		fl.small_fail = (small_nc > MAXC);
		fl.grow_done  = (gsum >= size_l);
		fl.grow_fail  = (newcap_q >= MAXC);
		fl.slots_fail = ((NW+1)'(count_q) + slots > MAXR);
		fl.gleft_pos  = (left_g != '0);
		fl.out_free   = !out_valid_q || out_ready;
	end

	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		ra = '0;
		unique case (cmd.op)
			OP_INIT: begin
				we = 1'b1;
				wd = {CW'(0), init_c[CW-1:0], 1'b1};
			end
			OP_FIND_RD, OP_AS_RD: ra = i_q[IW-1:0];
			OP_FP_RD: ra = em1[IW-1:0];
			OP_FN_RD: ra = ep1[IW-1:0];
			OP_FW: begin
				we = 1'b1;
				wa = lo_q[IW-1:0];
				wd = {cur_start_q, cur_len_q, 1'b1};
			end
			OP_SH_RD: ra = jk[IW-1:0];
			OP_SH_WR, OP_IN_WR: begin
				we = 1'b1;
				wa = j_q[IW-1:0];
				wd = rd_q;
			end
			OP_BEST_WR: begin
				we = 1'b1;
				wa = b_idx_q[IW-1:0];
				wd = {b_start_q, size_c, 1'b0};
			end
			OP_IN_RD: begin
				if (j_q > pos_q) begin
					ra = IW'(j_q - NW'(1));
				end else begin
					we = 1'b1;
					wa = pos_q[IW-1:0];
					wd = {n_start_q, n_len_q, 1'b1};
				end
			end
			OP_GCHK: begin
				we = 1'b1;
				wa = pidx[IW-1:0];
				wd = {pstart, size_c, 1'b0};
			end
			OP_GW2: begin
				we = 1'b1;
				wa = pos_q[IW-1:0];
				wd = {n_start_q, n_len_q, 1'b1};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= INIT_CAP_RST;
			gf_q        <= GF_RST;
			init_pend_q <= 1'b1;
			cap_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_INIT) init_pend_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_INIT_CAP: begin
						init_q      <= cfg_wdata;
						init_pend_q <= 1'b1;
					end
					CFG_GROWTH: gf_q <= cfg_wdata[GF_W-1:0];
				endcase
			end
			if (cmd.op == OP_LOAD_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (cmd.op)
				OP_INIT: begin
					cap_q   <= init_c[CW-1:0];
					count_q <= NW'(1);
				end
				OP_SH_RD: if (!fl.sh_more) count_q <= count_q - k_q;
				OP_IN_RD: if (!fl.in_more) count_q <= count_q + NW'(1);
				OP_GCHK: begin
					cap_q   <= newcap_q[CW-1:0];
					count_q <= gcount[NW-1:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ACCEPT: begin
				type_q <= in_req_type;
				addr_q <= in_address;
				size_q <= in_request_size;
			end
			OP_DISP: begin
				i_q       <= '0;
				bv_q      <= 1'b0;
				raddr_q   <= '0;
				resized_q <= 1'b0;
			end
			OP_FIND_CHK: begin
				if (fl.match) begin
					e_idx_q   <= i_q;
					e_start_q <= rd_start;
					e_len_q   <= rd_len;
				end else begin
					i_q <= i_q + NW'(1);
				end
			end
			OP_FP_RD: begin
				lo_q        <= e_idx_q;
				cur_start_q <= e_start_q;
				cur_len_q   <= e_len_q;
			end
			OP_FP_CHK: if (rd_free) begin
				lo_q        <= em1;
				cur_start_q <= rd_start;
				cur_len_q   <= rd_len + e_len_q;
			end
			OP_FN_RD: hi_q <= e_idx_q;
			OP_FN_CHK: if (rd_free) begin
				cur_len_q <= cur_len_q + rd_len;
				hi_q      <= ep1[NW-1:0];
			end
			OP_FW: begin
				j_q <= lo_q + NW'(1);
				k_q <= hi_q - lo_q;
			end
			OP_SH_WR: j_q <= j_q + NW'(1);
			OP_AF: begin
				i_q  <= '0;
				bv_q <= 1'b0;
			end
			OP_AS_CHK: begin
				if (cand) begin
					bv_q      <= 1'b1;
					b_idx_q   <= i_q;
					b_start_q <= rd_start;
					b_len_q   <= rd_len;
				end
				if (fl.i_last) begin
					last_start_q <= rd_start;
					last_len_q   <= rd_len;
					last_free_q  <= rd_free;
				end else begin
					i_q <= i_q + NW'(1);
				end
			end
			OP_BEST_WR: begin
				raddr_q   <= to_addr(b_start_q);
				pos_q     <= bp1[NW-1:0];
				j_q       <= count_q;
				n_start_q <= b_start_q + size_c;
				n_len_q   <= b_len_q - size_c;
			end
			OP_SET_SMALL: newcap_q <= small_nc;
			OP_SET_NC:    newcap_q <= cap_l;
			OP_IN_WR:     j_q <= j_q - NW'(1);
			OP_GROW_STEP: newcap_q <= step_nc;
			OP_GCHK: begin
				raddr_q   <= to_addr(pstart);
				resized_q <= 1'b1;
				pos_q     <= pp1[NW-1:0];
				n_start_q <= pstart + size_c;
				n_len_q   <= left_g[CW-1:0];
			end
			OP_LOAD_OUT: begin
				o_status_q  <= status_q;
				o_addr_q    <= (status_q == ST_OK) ? raddr_q : '0;
				o_resized_q <= resized_q;
			end
			default: ;
		endcase
		if (cmd.set_res) begin
			status_q <= cmd.st;
			if (cmd.res_addr) raddr_q <= addr_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_status  = o_status_q;
	assign out_address = o_addr_q;
	assign out_resized = o_resized_q;

endmodule

FILE: sv/bfra_ctrl.sv
// Controller: request sequencer for find, free with merge, best-fit scan and growth.
module bfra_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  bfra_pkg::flags_t fl,
	output bfra_pkg::cmd_t   cmd
);
	import bfra_pkg::*;

	typedef enum logic [21:0] {
		S_IDLE     = 22'b1 << 0,
		S_INIT     = 22'b1 << 1,
		S_DISP     = 22'b1 << 2,
		S_FIND_RD  = 22'b1 << 3,
		S_FIND_CHK = 22'b1 << 4,
		S_FP_RD    = 22'b1 << 5,
		S_FP_CHK   = 22'b1 << 6,
		S_FN_RD    = 22'b1 << 7,
		S_FN_CHK   = 22'b1 << 8,
		S_FW       = 22'b1 << 9,
		S_SH_RD    = 22'b1 << 10,
		S_SH_WR    = 22'b1 << 11,
		S_AF       = 22'b1 << 12,
		S_AS_RD    = 22'b1 << 13,
		S_AS_CHK   = 22'b1 << 14,
		S_AS_DEC   = 22'b1 << 15,
		S_IN_RD    = 22'b1 << 16,
		S_IN_WR    = 22'b1 << 17,
		S_GROW     = 22'b1 << 18,
		S_GCHK     = 22'b1 << 19,
		S_GW2      = 22'b1 << 20,
		S_DONE     = 22'b1 << 21
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE) && !fl.init_pend;

	always_comb begin
		state_d = state_q;
		cmd     = '{op: OP_NONE, set_res: 1'b0, st: ST_OK, res_addr: 1'b0};
		unique case (state_q)
			S_IDLE: begin
				if (fl.init_pend) begin
					state_d = S_INIT;
				end else if (req_valid) begin
					cmd.op  = OP_ACCEPT;
					state_d = S_DISP;
				end
			end
			S_INIT: begin
				cmd.op  = OP_INIT;
				state_d = S_IDLE;
			end
			S_DISP: begin
				cmd.op = OP_DISP;
				priority if (fl.req_type == REQ_ALLOC) begin
					if (fl.size_zero) begin
						cmd.set_res = 1'b1;
						cmd.st      = ST_ZERO;
						state_d     = S_DONE;
					end else begin
						state_d = S_AS_RD;
					end
				end else if (fl.req_type == REQ_FREE || fl.req_type == REQ_REALLOC) begin
					state_d = S_FIND_RD;
				end else begin
					cmd.set_res = 1'b1;
					cmd.st      = ST_NOENT;
					state_d     = S_DONE;
				end
			end
			S_FIND_RD: begin
				cmd.op  = OP_FIND_RD;
				state_d = S_FIND_CHK;
			end
			S_FIND_CHK: begin
				cmd.op = OP_FIND_CHK;
				priority if (fl.match && fl.rd_free) begin
					cmd.set_res = 1'b1;
					cmd.st      = ST_NOENT;
					state_d     = S_DONE;
				end else if (fl.match && fl.req_type == REQ_REALLOC && fl.same) begin
					cmd.set_res  = 1'b1;
					cmd.res_addr = 1'b1;
					state_d      = S_DONE;
				end else if (fl.match) begin
					state_d = S_FP_RD;
				end else if (fl.i_last) begin
					cmd.set_res = 1'b1;
					cmd.st      = ST_NOENT;
					state_d     = S_DONE;
				end else begin
					state_d = S_FIND_RD;
				end
			end
			S_FP_RD: begin
				cmd.op  = OP_FP_RD;
				state_d = fl.has_prev ? S_FP_CHK : S_FN_RD;
			end
			S_FP_CHK: begin
				cmd.op  = OP_FP_CHK;
				state_d = S_FN_RD;
			end
			S_FN_RD: begin
				cmd.op  = OP_FN_RD;
				state_d = fl.has_next ? S_FN_CHK : S_FW;
			end
			S_FN_CHK: begin
				cmd.op  = OP_FN_CHK;
				state_d = S_FW;
			end
			S_FW: begin
				cmd.op  = OP_FW;
				state_d = fl.k_zero ? S_AF : S_SH_RD;
			end
			S_SH_RD: begin
				cmd.op  = OP_SH_RD;
				state_d = fl.sh_more ? S_SH_WR : S_AF;
			end
			S_SH_WR: begin
				cmd.op  = OP_SH_WR;
				state_d = S_SH_RD;
			end
			S_AF: begin
				cmd.op = OP_AF;
				priority if (fl.req_type == REQ_FREE) begin
					cmd.set_res  = 1'b1;
					cmd.res_addr = 1'b1;
					state_d      = S_DONE;
				end else if (fl.size_zero) begin
					cmd.set_res = 1'b1;
					cmd.st      = ST_ZERO;
					state_d     = S_DONE;
				end else begin
					state_d = S_AS_RD;
				end
			end
			S_AS_RD: begin
				cmd.op  = OP_AS_RD;
				state_d = S_AS_CHK;
			end
			S_AS_CHK: begin
				cmd.op  = OP_AS_CHK;
				state_d = fl.i_last ? S_AS_DEC : S_AS_RD;
			end
			S_AS_DEC: begin
				priority if (fl.best_valid && fl.best_ovf) begin
					cmd.set_res = 1'b1;
					cmd.st      = ST_NOSPACE;
					state_d     = S_DONE;
				end else if (fl.best_valid) begin
					cmd.op = OP_BEST_WR;
					if (fl.best_exact) begin
						cmd.set_res = 1'b1;
						state_d     = S_DONE;
					end else begin
						state_d = S_IN_RD;
					end
				end else if (fl.small_gf && fl.small_fail) begin
					cmd.set_res = 1'b1;
					cmd.st      = ST_NOSPACE;
					state_d     = S_DONE;
				end else if (fl.small_gf) begin
					cmd.op  = OP_SET_SMALL;
					state_d = S_GCHK;
				end else begin
					cmd.op  = OP_SET_NC;
					state_d = S_GROW;
				end
			end
			S_IN_RD: begin
				cmd.op = OP_IN_RD;
				if (fl.in_more) begin
					state_d = S_IN_WR;
				end else begin
					cmd.set_res = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_IN_WR: begin
				cmd.op  = OP_IN_WR;
				state_d = S_IN_RD;
			end
			S_GROW: begin
				priority if (fl.grow_done) begin
					state_d = S_GCHK;
				end else if (fl.grow_fail) begin
					cmd.set_res = 1'b1;
					cmd.st      = ST_NOSPACE;
					state_d     = S_DONE;
				end else begin
					cmd.op = OP_GROW_STEP;
				end
			end
			S_GCHK: begin
				if (fl.slots_fail) begin
					cmd.set_res = 1'b1;
					cmd.st      = ST_NOSPACE;
					state_d     = S_DONE;
				end else begin
					cmd.op = OP_GCHK;
					if (fl.gleft_pos) begin
						state_d = S_GW2;
					end else begin
						cmd.set_res = 1'b1;
						state_d     = S_DONE;
					end
				end
			end
			S_GW2: begin
				cmd.op      = OP_GW2;
				cmd.set_res = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (fl.out_free) begin
					cmd.op  = OP_LOAD_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: sv/best_fit_region_allocator.sv
// Top level of the best-fit region allocator.
//
// Requests arrive on the req channel (valid/ready): allocate, free or
// reallocate, with an address and a size. Each request gives exactly one
// item on the rsp channel: status, placed address and a resized flag.
// The region table sits in a single-port memory with registered read, so
// every table entry visited takes a read step and a check step. A request
// walks the table to find its region, walks it again for the best-fit
// scan, shifts entries on a split or merge and steps the capacity up for
// growth, as its kind needs.
// One request is handled at a time; the next is taken as soon as the
// result sits in the output register, even if the receiver has not yet
// taken it. A stalled receiver holds the sequencer in its last step.
// After reset, and after a write of the initial capacity register, the
// pool is rebuilt as a single free region; no request is taken until it
// is done.
// Configuration is written through cfg_we/cfg_index/cfg_wdata.
module best_fit_region_allocator #(
	parameter int MAX_REGIONS  = 64,
	parameter int MAX_CAPACITY = 1048576
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [bfra_pkg::SIZE_W-1:0] cfg_wdata,
	bfra_req_if.sink                    req,
	bfra_rsp_if.source                  rsp
);
	import bfra_pkg::*;

	cmd_t   cmd;
	flags_t fl;
	logic   ready;

	bfra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.fl        (fl),
		.cmd       (cmd)
	);

	bfra_dp #(
		.MAX_REGIONS  (MAX_REGIONS),
		.MAX_CAPACITY (MAX_CAPACITY)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.fl              (fl),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_req_type     (req.req_type),
		.in_address      (req.address),
		.in_request_size (req.request_size),
		.out_ready       (rsp.ready),
		.out_valid       (rsp.valid),
		.out_status      (rsp.status),
		.out_address     (rsp.result_address),
		.out_resized     (rsp.resized)
	);

	assign req.ready = ready;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in flight");

	a_load_gives_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LOAD_OUT |=> rsp.valid)
		else $error("result load did not raise valid");

	a_resize_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (!rsp.resized || rsp.status == ST_OK))
		else $error("resized flag on a failed request");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LOAD_OUT |-> (!rsp.valid || rsp.ready))
		else $error("result overwritten before it was taken");

endmodule
